[rtl/ffia_pkg.sv]
// ----------------------------------------------------------------------------
// ffia_pkg
// Shared types and codes for the first-fit interval allocator.
// ----------------------------------------------------------------------------
package ffia_pkg;

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ZERO     = 3'd1;
   localparam logic [2:0] ST_UNKNOWN  = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] request_size;
      logic [31:0] release_offset;
   } req_type;

   typedef struct packed {
      logic [31:0] granted_offset;
      logic [2:0]  status;
      logic [31:0] high_water;
      logic [47:0] requested_total;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ASCAN,
      S_LSCAN,
      S_FSCAN,
      S_SHDN,
      S_SHUP,
      S_RESP
   } state_type;

endpackage

[rtl/ffia_ram.sv]
// ----------------------------------------------------------------------------
// ffia_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ffia_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ffia_rsp_reg.sv]
// ----------------------------------------------------------------------------
// ffia_rsp_reg
// Output register that holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module ffia_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_valid,
   output logic             load_ready,
   input  ffia_pkg::rsp_type load_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ffia_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   ffia_pkg::rsp_type data_ff;

   assign load_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[rtl/first_fit_interval_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_interval_allocator_top
// First-fit offset allocator with coalescing free list and live-block table.
// ----------------------------------------------------------------------------
// Usage: a request beat on req_* carries a mode (allocate, free, clear), a
// size and a release offset. Each request produces exactly one response beat
// on rsp_* with the granted offset, a status code, the high-water mark and the
// saturating total of requested sizes.
// The free intervals live in one RAM, sorted by start, and the live blocks in
// a second RAM. Both have a registered read. An allocation reads the whole
// free table once and then may shift the table down by one entry. A free
// request reads the live table, then the free table, and may shift part of
// the free table up or down. The table scans go through the single RAM read
// port of each table. Clear and unused modes go straight to the response.
// One item is worked on at a time; req_ready is high only while the
// sequencer is idle. Reset empties both tables by zeroing their counts, with
// no clearing pass. A finished result waits in an output register, so the
// next request is taken while the receiver stalls; the sequencer only waits
// if a second result is ready before the first one has been taken.
// ----------------------------------------------------------------------------
module first_fit_interval_allocator_top #(
   parameter int FREE_DEPTH  = 16,
   parameter int LIVE_DEPTH  = 32,
   parameter int OFFSET_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffia_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffia_pkg::rsp_type rsp_data
);

   localparam int OB = OFFSET_BITS;
   localparam int EW = 2 * OB;
   localparam int FI = $clog2(FREE_DEPTH);
   localparam int FC = $clog2(FREE_DEPTH + 1);
   localparam int LI = $clog2(LIVE_DEPTH);
   localparam int LC = $clog2(LIVE_DEPTH + 1);
   localparam int SW = ((OB > 32) ? OB : 32) + 1;

   // Sequencer state and totals.
   ffia_pkg::state_type state_ff, state_in;
   logic [FC-1:0] fc_ff, fc_in;
   logic [LC-1:0] lc_ff, lc_in;
   logic [OB-1:0] mark_ff, mark_in;
   logic [47:0]   sum_ff, sum_in;

   // Latched request.
   logic [31:0] size_ff, size_in;
   logic [31:0] off_ff, off_in;

   // Scan pointers; pend marks a read whose data arrives this cycle.
   logic [FC-1:0] fptr_ff, fptr_in, fpidx_ff, fpidx_in;
   logic [LC-1:0] lptr_ff, lptr_in, lpidx_ff, lpidx_in;
   logic          pend_ff, pend_in;

   // What the scans found.
   logic          hit_ff, hit_in;
   logic [FC-1:0] hit_idx_ff, hit_idx_in;
   logic [LC-1:0] lidx_ff, lidx_in;
   logic [OB-1:0] s_ff, s_in, e_ff, e_in;
   logic          nxv_ff, nxv_in;
   logic [OB-1:0] nxs_ff, nxs_in, nxe_ff, nxe_in;
   logic [OB-1:0] first_s_ff, first_s_in;
   logic [OB-1:0] last_s_ff, last_s_in, last_e_ff, last_e_in;
   logic [OB-1:0] lls_ff, lls_in, lle_ff, lle_in;
   logic          lo_v_ff, lo_v_in, hi_v_ff, hi_v_in;
   logic [FC-1:0] lo_idx_ff, lo_idx_in, hi_idx_ff, hi_idx_in;
   logic [OB-1:0] lo_s_ff, lo_s_in, hi_e_ff, hi_e_in;
   logic [FC-1:0] pos_ff, pos_in;

   // Staged result.
   logic [OB-1:0] gr_ff, gr_in;
   logic [2:0]    st_ff, st_in;

   // RAM ports.
   logic          f_we;
   logic [FI-1:0] f_waddr, f_raddr;
   logic [EW-1:0] f_wdata, f_rdata;
   logic          l_we;
   logic [LI-1:0] l_waddr, l_raddr;
   logic [EW-1:0] l_wdata, l_rdata;

   logic [OB-1:0] f_ds, f_de, l_ds, l_de;

   // Temporaries of the sequencer.
   logic [48:0]   sum_ext;
   logic [OB-1:0] new_s;
   logic [OB-1:0] tail_s;
   logic          tail_rm;
   logic [SW-1:0] tail_end;
   logic [FC-1:0] idx_tmp;

   logic              load_valid;
   logic              load_ready;
   ffia_pkg::rsp_type load_data;

   assign f_ds = f_rdata[EW-1:OB];
   assign f_de = f_rdata[OB-1:0];
   assign l_ds = l_rdata[EW-1:OB];
   assign l_de = l_rdata[OB-1:0];

   assign req_ready = (state_ff == ffia_pkg::S_IDLE);

   always_comb begin
      state_in   = state_ff;
      fc_in      = fc_ff;
      lc_in      = lc_ff;
      mark_in    = mark_ff;
      sum_in     = sum_ff;
      size_in    = size_ff;
      off_in     = off_ff;
      fptr_in    = fptr_ff;
      fpidx_in   = fpidx_ff;
      lptr_in    = lptr_ff;
      lpidx_in   = lpidx_ff;
      pend_in    = 1'b0;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      lidx_in    = lidx_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      nxv_in     = nxv_ff;
      nxs_in     = nxs_ff;
      nxe_in     = nxe_ff;
      first_s_in = first_s_ff;
      last_s_in  = last_s_ff;
      last_e_in  = last_e_ff;
      lls_in     = lls_ff;
      lle_in     = lle_ff;
      lo_v_in    = lo_v_ff;
      hi_v_in    = hi_v_ff;
      lo_idx_in  = lo_idx_ff;
      hi_idx_in  = hi_idx_ff;
      lo_s_in    = lo_s_ff;
      hi_e_in    = hi_e_ff;
      pos_in     = pos_ff;
      gr_in      = gr_ff;
      st_in      = st_ff;
      f_we       = 1'b0;
      f_waddr    = '0;
      f_wdata    = '0;
      f_raddr    = fptr_ff[FI-1:0];
      l_we       = 1'b0;
      l_waddr    = '0;
      l_wdata    = '0;
      l_raddr    = lptr_ff[LI-1:0];
      load_valid = 1'b0;
      sum_ext    = {1'b0, sum_ff} + {17'd0, size_ff};
      new_s      = s_ff + OB'(size_ff);
      tail_rm    = (fc_ff != '0) && (last_e_ff == mark_ff);
      tail_s     = tail_rm ? last_s_ff : mark_ff;
      tail_end   = SW'(tail_s) + SW'(size_ff);
      idx_tmp    = '0;

      case (state_ff)
         ffia_pkg::S_IDLE: begin
            if (req_valid) begin
               size_in = req_data.request_size;
               off_in  = req_data.release_offset;
               hit_in  = 1'b0;
               nxv_in  = 1'b0;
               case (req_data.mode)
                  ffia_pkg::MODE_ALLOC: begin
                     sum_ext = {1'b0, sum_ff} + {17'd0, req_data.request_size};
                     sum_in  = sum_ext[48] ? {48{1'b1}} : sum_ext[47:0];
                     fptr_in = '0;
                     state_in = ffia_pkg::S_ASCAN;
                  end
                  ffia_pkg::MODE_FREE: begin
                     lptr_in  = '0;
                     state_in = ffia_pkg::S_LSCAN;
                  end
                  ffia_pkg::MODE_CLEAR: begin
                     fc_in    = '0;
                     lc_in    = '0;
                     mark_in  = '0;
                     sum_in   = '0;
                     gr_in    = '0;
                     st_in    = ffia_pkg::ST_OK;
                     state_in = ffia_pkg::S_RESP;
                  end
                  default: begin
                     gr_in    = '0;
                     st_in    = ffia_pkg::ST_OK;
                     state_in = ffia_pkg::S_RESP;
                  end
               endcase
            end
         end

         ffia_pkg::S_ASCAN: begin
            if (fptr_ff < fc_ff) begin
               pend_in  = 1'b1;
               fpidx_in = fptr_ff;
               fptr_in  = fptr_ff + 1'b1;
            end
            if (pend_ff) begin
               if (fpidx_ff == '0) begin
                  first_s_in = f_ds;
               end
               if (fpidx_ff == fc_ff - 1'b1) begin
                  last_s_in = f_ds;
                  last_e_in = f_de;
               end
               if (!hit_ff && (SW'(f_de - f_ds) >= SW'(size_ff))) begin
                  hit_in     = 1'b1;
                  hit_idx_in = fpidx_ff;
                  s_in       = f_ds;
                  e_in       = f_de;
               end
               if (hit_ff && (fpidx_ff == hit_idx_ff + 1'b1)) begin
                  nxv_in = 1'b1;
                  nxs_in = f_ds;
                  nxe_in = f_de;
               end
            end
            if (!pend_ff && (fptr_ff >= fc_ff)) begin
               state_in = ffia_pkg::S_RESP;
               gr_in    = '0;
               st_in    = ffia_pkg::ST_OK;
               if (size_ff == '0) begin
                  gr_in = (fc_ff != '0) ? first_s_ff : mark_ff;
                  st_in = ffia_pkg::ST_ZERO;
               end else if (lc_ff == LC'(LIVE_DEPTH)) begin
                  st_in = ffia_pkg::ST_FULL;
               end else if (hit_ff) begin
                  // First fit: the block goes at the interval's start.
                  l_we    = 1'b1;
                  l_waddr = lc_ff[LI-1:0];
                  l_wdata = {s_ff, new_s};
                  lc_in   = lc_ff + 1'b1;
                  gr_in   = s_ff;
                  if (new_s == e_ff) begin
                     fptr_in  = hit_idx_ff + 1'b1;
                     state_in = ffia_pkg::S_SHDN;
                  end else if (nxv_ff && (nxs_ff == e_ff)) begin
                     f_we     = 1'b1;
                     f_waddr  = hit_idx_ff[FI-1:0];
                     f_wdata  = {new_s, nxe_ff};
                     fptr_in  = hit_idx_ff + 2'd2;
                     state_in = ffia_pkg::S_SHDN;
                  end else begin
                     f_we    = 1'b1;
                     f_waddr = hit_idx_ff[FI-1:0];
                     f_wdata = {new_s, e_ff};
                  end
               end else if ((tail_end >> OB) != '0) begin
                  st_in = ffia_pkg::ST_OVERFLOW;
               end else begin
                  // Grow at the tail, reusing a free interval that ends there.
                  mark_in = tail_end[OB-1:0];
                  l_we    = 1'b1;
                  l_waddr = lc_ff[LI-1:0];
                  l_wdata = {tail_s, tail_end[OB-1:0]};
                  lc_in   = lc_ff + 1'b1;
                  gr_in   = tail_s;
                  if (tail_rm) begin
                     fc_in = fc_ff - 1'b1;
                  end
               end
            end
         end

         ffia_pkg::S_LSCAN: begin
            if (lptr_ff < lc_ff) begin
               pend_in  = 1'b1;
               lpidx_in = lptr_ff;
               lptr_in  = lptr_ff + 1'b1;
            end
            if (pend_ff) begin
               if (lpidx_ff == lc_ff - 1'b1) begin
                  lls_in = l_ds;
                  lle_in = l_de;
               end
               if (!hit_ff && (SW'(l_ds) == SW'(off_ff))) begin
                  hit_in  = 1'b1;
                  lidx_in = lpidx_ff;
                  s_in    = l_ds;
                  e_in    = l_de;
               end
            end
            if (!pend_ff && (lptr_ff >= lc_ff)) begin
               if (!hit_ff) begin
                  gr_in    = '0;
                  st_in    = ffia_pkg::ST_UNKNOWN;
                  state_in = ffia_pkg::S_RESP;
               end else begin
                  fptr_in  = '0;
                  lo_v_in  = 1'b0;
                  hi_v_in  = 1'b0;
                  pos_in   = '0;
                  state_in = ffia_pkg::S_FSCAN;
               end
            end
         end

         ffia_pkg::S_FSCAN: begin
            if (fptr_ff < fc_ff) begin
               pend_in  = 1'b1;
               fpidx_in = fptr_ff;
               fptr_in  = fptr_ff + 1'b1;
            end
            if (pend_ff) begin
               if (!lo_v_ff && (f_de == s_ff)) begin
                  lo_v_in   = 1'b1;
                  lo_idx_in = fpidx_ff;
                  lo_s_in   = f_ds;
               end
               if (!hi_v_ff && (f_ds == e_ff)) begin
                  hi_v_in   = 1'b1;
                  hi_idx_in = fpidx_ff;
                  hi_e_in   = f_de;
               end
               if (f_ds <= s_ff) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            if (!pend_ff && (fptr_ff >= fc_ff)) begin
               gr_in    = '0;
               st_in    = ffia_pkg::ST_OK;
               state_in = ffia_pkg::S_RESP;
               if (!lo_v_ff && !hi_v_ff && (fc_ff == FC'(FREE_DEPTH))) begin
                  st_in = ffia_pkg::ST_FULL;
               end else begin
                  // Retire the live block by moving the last entry into its slot.
                  l_we    = 1'b1;
                  l_waddr = lidx_ff[LI-1:0];
                  l_wdata = {lls_ff, lle_ff};
                  lc_in   = lc_ff - 1'b1;
                  if (lo_v_ff && hi_v_ff) begin
                     f_we     = 1'b1;
                     f_waddr  = lo_idx_ff[FI-1:0];
                     f_wdata  = {lo_s_ff, hi_e_ff};
                     fptr_in  = hi_idx_ff + 1'b1;
                     state_in = ffia_pkg::S_SHDN;
                  end else if (lo_v_ff) begin
                     f_we    = 1'b1;
                     f_waddr = lo_idx_ff[FI-1:0];
                     f_wdata = {lo_s_ff, e_ff};
                  end else if (hi_v_ff) begin
                     f_we    = 1'b1;
                     f_waddr = hi_idx_ff[FI-1:0];
                     f_wdata = {s_ff, hi_e_ff};
                  end else begin
                     fptr_in  = fc_ff;
                     state_in = ffia_pkg::S_SHUP;
                  end
               end
            end
         end

         ffia_pkg::S_SHDN: begin
            // Close a gap: entry k+1 moves to k up to the end of the table.
            if (fptr_ff < fc_ff) begin
               pend_in  = 1'b1;
               fpidx_in = fptr_ff;
               fptr_in  = fptr_ff + 1'b1;
            end
            if (pend_ff) begin
               idx_tmp = fpidx_ff - 1'b1;
               f_we    = 1'b1;
               f_waddr = idx_tmp[FI-1:0];
               f_wdata = f_rdata;
            end
            if (!pend_ff && (fptr_ff >= fc_ff)) begin
               fc_in    = fc_ff - 1'b1;
               state_in = ffia_pkg::S_RESP;
            end
         end

         ffia_pkg::S_SHUP: begin
            // Open a gap at the insert position, working down from the top.
            idx_tmp = fptr_ff - 1'b1;
            f_raddr = idx_tmp[FI-1:0];
            if (fptr_ff > pos_ff) begin
               pend_in  = 1'b1;
               fpidx_in = idx_tmp;
               fptr_in  = idx_tmp;
            end
            if (pend_ff) begin
               idx_tmp = fpidx_ff + 1'b1;
               f_we    = 1'b1;
               f_waddr = idx_tmp[FI-1:0];
               f_wdata = f_rdata;
            end
            if (!pend_ff && (fptr_ff <= pos_ff)) begin
               f_we     = 1'b1;
               f_waddr  = pos_ff[FI-1:0];
               f_wdata  = {s_ff, e_ff};
               fc_in    = fc_ff + 1'b1;
               state_in = ffia_pkg::S_RESP;
            end
         end

         ffia_pkg::S_RESP: begin
            load_valid = 1'b1;
            if (load_ready) begin
               state_in = ffia_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ffia_pkg::S_IDLE;
         end
      endcase
   end

   assign load_data.granted_offset  = 32'(gr_ff);
   assign load_data.status          = st_ff;
   assign load_data.high_water      = 32'(mark_ff);
   assign load_data.requested_total = sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffia_pkg::S_IDLE;
         fc_ff    <= '0;
         lc_ff    <= '0;
         mark_ff  <= '0;
         sum_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fc_ff    <= fc_in;
         lc_ff    <= lc_in;
         mark_ff  <= mark_in;
         sum_ff   <= sum_in;
         pend_ff  <= pend_in;
      end
      size_ff    <= size_in;
      off_ff     <= off_in;
      fptr_ff    <= fptr_in;
      fpidx_ff   <= fpidx_in;
      lptr_ff    <= lptr_in;
      lpidx_ff   <= lpidx_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      lidx_ff    <= lidx_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      nxv_ff     <= nxv_in;
      nxs_ff     <= nxs_in;
      nxe_ff     <= nxe_in;
      first_s_ff <= first_s_in;
      last_s_ff  <= last_s_in;
      last_e_ff  <= last_e_in;
      lls_ff     <= lls_in;
      lle_ff     <= lle_in;
      lo_v_ff    <= lo_v_in;
      hi_v_ff    <= hi_v_in;
      lo_idx_ff  <= lo_idx_in;
      hi_idx_ff  <= hi_idx_in;
      lo_s_ff    <= lo_s_in;
      hi_e_ff    <= hi_e_in;
      pos_ff     <= pos_in;
      gr_ff      <= gr_in;
      st_ff      <= st_in;
   end

   ffia_ram #(.WIDTH(EW), .DEPTH(FREE_DEPTH)) u_free_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   ffia_ram #(.WIDTH(EW), .DEPTH(LIVE_DEPTH)) u_live_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_addr (l_raddr),
      .rd_data (l_rdata)
   );

   ffia_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load_ready (load_ready),
      .load_data  (load_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // The free count never exceeds the table depth.
   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= FC'(FREE_DEPTH))
      else $error("free count above table depth");

   // The live count never exceeds the table depth.
   a_lc_bound: assert property (@(posedge clock) disable iff (reset)
      lc_ff <= LC'(LIVE_DEPTH))
      else $error("live count above table depth");

   // A response beat only appears after the sequencer hands one over.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ffia_pkg::S_RESP))
      else $error("response without a finished item");

   // Neither table is written while the sequencer is idle.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffia_pkg::S_IDLE) |-> (!f_we && !l_we))
      else $error("table write while idle");

endmodule
